@@ src/lts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the LCD timing and STAT controller.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int DOTS_PER_LINE   = 456;
    localparam int LINES_PER_FRAME = 154;
    localparam int VISIBLE_LINES   = 144;
    localparam int OAM_LAST_DOT    = 80;
    localparam int DRAW_LAST_DOT   = 168;

    localparam int DOT_W  = $clog2(DOTS_PER_LINE);
    localparam int LINE_W = 8;

    // request kinds
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    // register addresses, low byte of page 0xff00
    localparam logic [7:0] ADDR_LCDC = 8'h40;
    localparam logic [7:0] ADDR_STAT = 8'h41;
    localparam logic [7:0] ADDR_SCY  = 8'h42;
    localparam logic [7:0] ADDR_SCX  = 8'h43;
    localparam logic [7:0] ADDR_LY   = 8'h44;
    localparam logic [7:0] ADDR_LYC  = 8'h45;
    localparam logic [7:0] ADDR_DMA  = 8'h46;
    localparam logic [7:0] ADDR_BGP  = 8'h47;
    localparam logic [7:0] ADDR_OBP0 = 8'h48;
    localparam logic [7:0] ADDR_OBP1 = 8'h49;
    localparam logic [7:0] ADDR_WY   = 8'h4A;
    localparam logic [7:0] ADDR_WX   = 8'h4B;
    localparam logic [7:0] ADDR_OPRI = 8'h6C;

    // display modes in STAT[1:0]
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // stat source line bits
    localparam int SRC_HBLANK = 0;
    localparam int SRC_VBLANK = 1;
    localparam int SRC_OAM    = 2;
    localparam int SRC_CMP    = 3;

    localparam logic [7:0] STAT_WR_MASK = 8'h78;
    localparam logic [7:0] DMA_MAX_PAGE = 8'hDF;
    localparam logic [7:0] READ_NONE    = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] io_address;
        logic [7:0] write_data;
        logic       dma_pending;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       stat_irq;
        logic       vblank_irq;
        logic       render_line;
        logic [7:0] line_index;
        logic       frame_ready;
        logic       blank_screen;
        logic       dma_request;
    } t_result;

endpackage

@@ src/lts_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_in_reg
// Input register: captures one request per cycle from the input channel while it is empty or advancing.
// ----------------------------------------------------------------------------
module lts_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lts_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output lts_pkg::t_item o_item
);
    import lts_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/lts_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_engine
// Register file, line/dot timing, mode and STAT interrupt logic. Computes
// the result of the request in the input register; state commits on fire.
// ----------------------------------------------------------------------------
module lts_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lts_pkg::t_item   i_item,
    output lts_pkg::t_result o_result
);
    import lts_pkg::*;

    logic [7:0]       r_lcdc, r_stat, r_scy, r_scx, r_lyc, r_dma;
    logic [7:0]       r_bgp, r_obp0, r_obp1, r_wy, r_wx, r_opri;
    logic [7:0]       n_lcdc, n_stat, n_scy, n_scx, n_lyc, n_dma;
    logic [7:0]       n_bgp, n_obp0, n_obp1, n_wy, n_wx, n_opri;
    logic [3:0]       r_src, n_src;
    logic             r_rendered, n_rendered, r_shown, n_shown;
    logic [LINE_W-1:0] r_line, n_line;
    // dot within the line; the frame dot is line * DOTS_PER_LINE + this
    logic [DOT_W-1:0] r_ldot, n_ldot;

    t_result          res;
    logic             ldot_wrap;
    logic [DOT_W-1:0] dot;
    logic [1:0]       mode;
    logic             req;

    assign o_result = res;

    always_comb begin
        n_lcdc = r_lcdc; n_stat = r_stat; n_scy = r_scy; n_scx = r_scx;
        n_lyc = r_lyc; n_dma = r_dma; n_bgp = r_bgp; n_obp0 = r_obp0;
        n_obp1 = r_obp1; n_wy = r_wy; n_wx = r_wx; n_opri = r_opri;
        n_src = r_src; n_rendered = r_rendered; n_shown = r_shown;
        n_line = r_line; n_ldot = r_ldot;
        ldot_wrap = (r_ldot == DOT_W'(DOTS_PER_LINE - 1));
        dot  = ldot_wrap ? '0 : r_ldot + DOT_W'(1);
        mode = MODE_HBLANK;
        req  = 1'b0;

        res              = '0;
        res.read_data    = READ_NONE;
        res.line_index   = r_line;

        case (i_item.func)
            FUNC_TICK: begin
                if (r_lcdc[7]) begin
                    if (r_line >= LINE_W'(VISIBLE_LINES)) begin
                        mode = MODE_VBLANK;
                    end else if (dot <= DOT_W'(OAM_LAST_DOT)) begin
                        mode = MODE_OAM;
                    end else if (dot <= DOT_W'(DRAW_LAST_DOT)) begin
                        mode = MODE_DRAW;
                    end else begin
                        mode = MODE_HBLANK;
                    end
                    n_stat[1:0] = mode;

                    case (mode)
                        MODE_HBLANK: begin
                            if (r_stat[3]) begin
                                req = 1'b1;
                                n_src[SRC_HBLANK] = 1'b1;
                            end
                        end
                        MODE_VBLANK: begin
                            n_src[SRC_HBLANK] = 1'b0;
                            if (r_stat[4]) begin
                                req = 1'b1;
                                n_src[SRC_VBLANK] = 1'b1;
                            end
                        end
                        MODE_OAM: begin
                            n_src[SRC_HBLANK] = 1'b0;
                            n_src[SRC_VBLANK] = 1'b0;
                            if (r_stat[5]) begin
                                req = 1'b1;
                                n_src[SRC_OAM] = 1'b1;
                            end
                        end
                        default: begin
                            n_src[SRC_HBLANK] = 1'b0;
                            n_src[SRC_VBLANK] = 1'b0;
                            n_src[SRC_OAM]    = 1'b0;
                        end
                    endcase
                    // edge against the source level before this tick
                    res.stat_irq = req && (r_src == 4'd0);

                    if (r_line == r_lyc) begin
                        n_stat[2] = 1'b1;
                        if (r_stat[6] && (n_src == 4'd0)) begin
                            res.stat_irq   = 1'b1;
                            n_src[SRC_CMP] = 1'b1;
                        end
                    end else begin
                        n_stat[2]      = 1'b0;
                        n_src[SRC_CMP] = 1'b0;
                    end

                    if (mode == MODE_HBLANK && !r_rendered) begin
                        res.render_line = 1'b1;
                        n_rendered      = 1'b1;
                    end else if (mode == MODE_VBLANK && !r_shown) begin
                        res.vblank_irq  = 1'b1;
                        res.frame_ready = 1'b1;
                        n_shown         = 1'b1;
                    end

                    n_ldot = dot;
                    if (ldot_wrap) begin
                        n_rendered = 1'b0;
                        if (r_line == LINE_W'(LINES_PER_FRAME - 1)) begin
                            n_line  = '0;
                            n_shown = 1'b0;
                        end else begin
                            n_line = r_line + LINE_W'(1);
                        end
                    end
                end
            end
            FUNC_READ: begin
                case (i_item.io_address)
                    ADDR_LCDC: res.read_data = r_lcdc;
                    ADDR_STAT: res.read_data = r_stat;
                    ADDR_SCY:  res.read_data = r_scy;
                    ADDR_SCX:  res.read_data = r_scx;
                    ADDR_LY:   res.read_data = r_line;
                    ADDR_LYC:  res.read_data = r_lyc;
                    ADDR_DMA:  res.read_data = r_dma;
                    ADDR_BGP:  res.read_data = r_bgp;
                    ADDR_OBP0: res.read_data = r_obp0;
                    ADDR_OBP1: res.read_data = r_obp1;
                    ADDR_WY:   res.read_data = r_wy;
                    ADDR_WX:   res.read_data = r_wx;
                    ADDR_OPRI: res.read_data = r_opri;
                    default:   res.read_data = READ_NONE;
                endcase
            end
            FUNC_WRITE: begin
                case (i_item.io_address)
                    ADDR_LCDC: begin
                        if (!i_item.write_data[7]) begin
                            n_line      = '0;
                            n_ldot      = '0;
                            n_stat[2:0] = 3'd0;
                            n_src       = 4'd0;
                            n_rendered  = 1'b0;
                            n_shown     = 1'b0;
                            res.blank_screen = 1'b1;
                        end
                        n_lcdc = i_item.write_data;
                    end
                    ADDR_STAT: begin
                        n_stat = (i_item.write_data & STAT_WR_MASK)
                               | (r_stat & ~STAT_WR_MASK);
                    end
                    ADDR_SCY: n_scy = i_item.write_data;
                    ADDR_SCX: n_scx = i_item.write_data;
                    ADDR_LYC: n_lyc = i_item.write_data;
                    ADDR_DMA: begin
                        res.dma_request = (i_item.write_data <= DMA_MAX_PAGE)
                                        && !i_item.dma_pending;
                        n_dma = i_item.write_data;
                    end
                    ADDR_BGP:  n_bgp  = i_item.write_data;
                    ADDR_OBP0: n_obp0 = i_item.write_data;
                    ADDR_OBP1: n_obp1 = i_item.write_data;
                    ADDR_WY:   n_wy   = i_item.write_data;
                    ADDR_WX:   n_wx   = i_item.write_data;
                    ADDR_OPRI: n_opri = {7'h7F, i_item.write_data[0]};
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= 8'h91; r_stat <= 8'h85; r_scy <= 8'h00; r_scx <= 8'h00;
            r_lyc <= 8'h00; r_dma <= 8'hFF; r_bgp <= 8'hFC; r_obp0 <= 8'hFF;
            r_obp1 <= 8'hFF; r_wy <= 8'h00; r_wx <= 8'h00; r_opri <= 8'h00;
            r_src <= 4'd0; r_rendered <= 1'b0; r_shown <= 1'b0;
            r_line <= '0; r_ldot <= '0;
        end else if (i_fire) begin
            r_lcdc <= n_lcdc; r_stat <= n_stat; r_scy <= n_scy; r_scx <= n_scx;
            r_lyc <= n_lyc; r_dma <= n_dma; r_bgp <= n_bgp; r_obp0 <= n_obp0;
            r_obp1 <= n_obp1; r_wy <= n_wy; r_wx <= n_wx; r_opri <= n_opri;
            r_src <= n_src; r_rendered <= n_rendered; r_shown <= n_shown;
            r_line <= n_line; r_ldot <= n_ldot;
        end
    end

endmodule

@@ src/lts_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_out_reg
// Result register toward the output channel; frees itself as it is taken.
// ----------------------------------------------------------------------------
module lts_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lts_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lts_pkg::t_result o_result
);
    import lts_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ src/lcd_timing_stat_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_timing_stat_controller_core
// LCD line/dot timing, mode tracking, STAT and vblank interrupts and the
// video register file, one request per dot clock while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_func i_io_address i_write_data
//                                       i_dma_pending
//  output    o_out_valid / i_out_ready  o_read_data o_stat_irq o_vblank_irq
//                                       o_render_line o_line_index
//                                       o_frame_ready o_blank_screen
//                                       o_dma_request
//
//  one request per cycle while the output is not stalled; an accepted request
//  passes the input register, then the result register, to the outputs
//  timing state is a line counter and a 9-bit dot-in-line counter
//  a stalled output holds the result; input keeps flowing while room remains
//  synchronous reset restores the register file to its power-on values
// ----------------------------------------------------------------------------
module lcd_timing_stat_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_io_address,
    input  logic [7:0] i_write_data,
    input  logic       i_dma_pending,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_stat_irq,
    output logic       o_vblank_irq,
    output logic       o_render_line,
    output logic [7:0] o_line_index,
    output logic       o_frame_ready,
    output logic       o_blank_screen,
    output logic       o_dma_request
);
    import lts_pkg::*;

    t_item   in_item, stage_item;
    t_result eng_result, out_result;
    logic    stage_valid, advance, fire;

    assign in_item.func        = i_func;
    assign in_item.io_address  = i_io_address;
    assign in_item.write_data  = i_write_data;
    assign in_item.dma_pending = i_dma_pending;

    assign fire = stage_valid && advance;

    lts_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .i_advance  (advance),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    lts_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (eng_result)
    );

    lts_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (eng_result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_stat_irq     = out_result.stat_irq;
    assign o_vblank_irq   = out_result.vblank_irq;
    assign o_render_line  = out_result.render_line;
    assign o_line_index   = out_result.line_index;
    assign o_frame_ready  = out_result.frame_ready;
    assign o_blank_screen = out_result.blank_screen;
    assign o_dma_request  = out_result.dma_request;

endmodule

@@ src/lts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks on the controller's result stream.
// ----------------------------------------------------------------------------
module lts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data,
    input logic       o_stat_irq,
    input logic       o_vblank_irq,
    input logic       o_render_line,
    input logic [7:0] o_line_index,
    input logic       o_frame_ready,
    input logic       o_blank_screen,
    input logic       o_dma_request
);
    import lts_pkg::*;

    a_frame_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_ready == o_vblank_irq))
        else $error("frame_ready and vblank_irq disagree");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_index <= 8'(LINES_PER_FRAME - 1)))
        else $error("line index beyond frame");

    a_render_not_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_render_line && o_vblank_irq))
        else $error("render and vblank in one request");

    a_blank_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_blank_screen) |->
            (!o_stat_irq && !o_render_line && !o_dma_request
             && o_read_data == READ_NONE))
        else $error("display-off write produced other effects");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_line_index) && $stable(o_stat_irq)))
        else $error("stalled result changed");

endmodule

bind lcd_timing_stat_controller_core lts_checker u_lts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_read_data    (o_read_data),
    .o_stat_irq     (o_stat_irq),
    .o_vblank_irq   (o_vblank_irq),
    .o_render_line  (o_render_line),
    .o_line_index   (o_line_index),
    .o_frame_ready  (o_frame_ready),
    .o_blank_screen (o_blank_screen),
    .o_dma_request  (o_dma_request)
);
